/* hdl/sssg_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the waveform generator.
package sssg_pkg;

  localparam int TIME_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int DUTY_W   = 17;
  localparam int SINE_N   = 1024;
  localparam int SINE_B   = $clog2(SINE_N);
  localparam int QTAB     = SINE_N / 4 + 1;
  localparam int QIDX_W   = SINE_B - 2;
  localparam int SMAG_W   = 31;
  localparam int NCELL    = TIME_W + SINE_B;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(65536);

  typedef enum logic [1:0] {
    MODE_STEP   = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_SINE   = 2'd2,
    MODE_CONST  = 2'd3
  } wave_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_CHANGE = 3'd2,
    REG_PERIOD = 3'd3,
    REG_DUTY   = 3'd4,
    REG_ACT    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] dvd;
    logic [SINE_B-1:0] quo;
    logic              step;
    logic              sq;
  } cell_t;

  typedef logic [SMAG_W-1:0] qsin_tab_t [QTAB];

  function automatic longint mq30(longint a, longint b);
    longint p;
    p = a * b;
    return p / 64'sd1073741824;
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    longint t, t2, p, s;
    for (int j = 0; j < QTAB; j++) begin
      t  = longint'(j) <<< (30 - QIDX_W);
      t2 = (t * t) >>> 30;
      p  = 64'sd172272;
      p  = -64'sd5026995 + mq30(p, t2);
      p  = 64'sd85569306 + mq30(p, t2);
      p  = -64'sd693598668 + mq30(p, t2);
      p  = 64'sd1686629713 + mq30(p, t2);
      s  = mq30(p, t);
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      tab[j] = SMAG_W'(s);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

endpackage

/* hdl/sssg_div_cell.sv */
// One restoring-division step: shifts a dividend bit into the remainder and emits a quotient bit.
module sssg_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [sssg_pkg::TIME_W-1:0] per_i,
  input  sssg_pkg::cell_t           cell_i,
  output sssg_pkg::cell_t           cell_o
);
  import sssg_pkg::*;

  logic [TIME_W:0] sh;
  logic            ge;
  cell_t           cell_d, cell_q;

  always_comb begin
    sh = {cell_i.rem, cell_i.dvd[TIME_W-1]};
    ge = sh >= {1'b0, per_i};
    cell_d       = cell_i;
    cell_d.rem   = ge ? TIME_W'(sh - {1'b0, per_i}) : TIME_W'(sh);
    cell_d.dvd   = {cell_i.dvd[TIME_W-2:0], 1'b0};
    cell_d.quo   = {cell_i.quo[SINE_B-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* hdl/sssg_wave_out.sv */
// Output stages: sine lookup, amplitude multiply, mode select and saturating add.
module sssg_wave_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  sssg_pkg::cell_t                   cell_i,
  input  sssg_pkg::wave_mode_e              mode_i,
  input  logic signed [sssg_pkg::VALUE_W-1:0] offset_i,
  input  logic signed [sssg_pkg::VALUE_W-1:0] change_i,
  output logic                              out_valid_o,
  output logic signed [sssg_pkg::VALUE_W-1:0] wave_value_o
);
  import sssg_pkg::*;

  localparam int PW = VALUE_W + SMAG_W;
  localparam int TW = VALUE_W + 2;
  localparam int SW = VALUE_W + 3;

  logic [QIDX_W-1:0] r;
  logic [QIDX_W:0]   idx;
  logic              a_valid_q, a_neg_q, a_step_q, a_sq_q;
  logic [SMAG_W-1:0] a_smag_q;
  logic              b_valid_q, b_step_q, b_sq_q;
  logic signed [TW-1:0] b_term_q;
  logic [VALUE_W:0]  amag;
  logic [PW:0]       prod;
  logic [TW-2:0]     rmag;
  logic signed [TW-1:0] term_d;
  logic signed [SW-1:0] sum_c, sum_s, sel;
  logic signed [VALUE_W-1:0] v_d;
  logic              out_valid_q;
  logic signed [VALUE_W-1:0] wave_q;

  localparam logic signed [SW-1:0] VMAX = SW'({1'b0, {(VALUE_W-1){1'b1}}});
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

  always_comb begin
    r   = cell_i.quo[QIDX_W-1:0];
    idx = cell_i.quo[SINE_B-2] ? ((QIDX_W+1)'(SINE_N / 4) - {1'b0, r}) : {1'b0, r};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_smag_q <= QSIN[idx];
      a_neg_q  <= cell_i.quo[SINE_B-1];
      a_step_q <= cell_i.step;
      a_sq_q   <= cell_i.sq;
    end
  end

  always_comb begin
    amag   = change_i[VALUE_W-1] ? (VALUE_W+1)'(-{change_i[VALUE_W-1], change_i})
                                 : {1'b0, change_i};
    prod   = (PW+1)'(amag) * (PW+1)'(a_smag_q) + (PW+1)'(1 << 29);
    rmag   = (TW-1)'(prod >> 30);
    term_d = (change_i[VALUE_W-1] ^ a_neg_q) ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_term_q <= term_d;
      b_step_q <= a_step_q;
      b_sq_q   <= a_sq_q;
    end
  end

  always_comb begin
    sum_c = SW'(offset_i) + SW'(change_i);
    sum_s = SW'(offset_i) + SW'(b_term_q);
    case (mode_i)
      MODE_STEP:   sel = b_step_q ? sum_c : SW'(offset_i);
      MODE_SQUARE: sel = b_sq_q ? sum_c : SW'(offset_i);
      MODE_SINE:   sel = sum_s;
      default:     sel = SW'(offset_i);
    endcase
    if (sel > VMAX)      v_d = VALUE_W'(VMAX);
    else if (sel < VMIN) v_d = VALUE_W'(VMIN);
    else                 v_d = VALUE_W'(sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wave_q <= v_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wave_value_o = wave_q;

endmodule

/* hdl/step_square_sine_generator.sv */
// Pipeline: 42 division cells, then 3 output stages, from an accepted input beat to its output beat.
// Throughput: one beat per cycle unless stalled; the whole chain of division cells advances together.
// The chain stalls only while the output register holds a beat that is not taken.
// Reset clears all valid bits and loads the register defaults: square mode, offset 0,
// change 1.0, period 10000, duty 0.5, activation tick 1000.
module step_square_sine_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sssg_pkg::TIME_W-1:0]          time_ticks_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sssg_pkg::VALUE_W-1:0]  wave_value_o,
  input  logic                                 cfg_we_i,
  input  logic [sssg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sssg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import sssg_pkg::*;

  wave_mode_e                mode_q;
  logic signed [VALUE_W-1:0] offset_q, change_q;
  logic [TIME_W-1:0]         per_q, act_q;
  logic [DUTY_W-1:0]         duty_q, duty_w;
  logic                      adv;
  logic [TIME_W+DUTY_W-1:0]  hi_lim;
  cell_t                     chain [NCELL+1];
  cell_t                     feed  [NCELL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SQUARE;
      offset_q <= '0;
      change_q <= VALUE_W'(65536);
      per_q    <= TIME_W'(10000);
      duty_q   <= DUTY_W'(32768);
      act_q    <= TIME_W'(1000);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:   mode_q   <= wave_mode_e'(cfg_data_i[1:0]);
        REG_OFFSET: offset_q <= VALUE_W'(cfg_data_i);
        REG_CHANGE: change_q <= VALUE_W'(cfg_data_i);
        REG_PERIOD: per_q    <= (cfg_data_i[TIME_W-1:0] == '0) ? TIME_W'(1)
                                                                : cfg_data_i[TIME_W-1:0];
        REG_DUTY:   duty_q   <= duty_w;
        REG_ACT:    act_q    <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign duty_w = (cfg_data_i[DUTY_W-1:0] > DUTY_ONE) ? DUTY_ONE : cfg_data_i[DUTY_W-1:0];

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign hi_lim     = (TIME_W+DUTY_W)'(per_q) * (TIME_W+DUTY_W)'(duty_q);

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = in_valid_i;
    chain[0].dvd   = time_ticks_i;
    chain[0].step  = time_ticks_i >= act_q;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == TIME_W) begin : g_sq
      always_comb begin
        feed[i]    = chain[i];
        feed[i].sq = (TIME_W+DUTY_W)'({chain[i].rem, 16'b0}) < hi_lim;
      end
    end else begin : g_pass
      assign feed[i] = chain[i];
    end
    sssg_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .per_i  (per_q),
      .cell_i (feed[i]),
      .cell_o (chain[i+1])
    );
  end

  sssg_wave_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .cell_i       (chain[NCELL]),
    .mode_i       (mode_q),
    .offset_i     (offset_q),
    .change_i     (change_q),
    .out_valid_o  (out_valid_o),
    .wave_value_o (wave_value_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output beat");

  a_per_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    per_q != '0)
    else $error("period register is zero");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_ONE)
    else $error("duty register above one");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(wave_value_o)))
    else $error("held output beat changed");

endmodule

/* tb/tb.sv */
// Self-checking testbench for step_square_sine_generator with a predictor and random stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sssg_pkg::*;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [TIME_W-1:0]           time_ticks_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0]   wave_value_o;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i = '0;

  step_square_sine_generator dut (.*);

  wave_mode_e          cur_mode;
  longint              cur_off, cur_chg;
  logic [TIME_W-1:0]   cur_per, cur_act;
  logic [DUTY_W-1:0]   cur_duty;

  logic signed [VALUE_W-1:0] wave_q[$];
  int  fail_cnt = 0;
  int  accepted = 0;
  bit  no_idle = 0;

  typedef struct {
    logic [TIME_W-1:0]         t;
    bit                        fixed;
    logic signed [VALUE_W-1:0] val;
  } dir_row_t;

  // reset config: square, period 10000, duty 0.5, change 1.0
  dir_row_t dir_tab[] = '{
    '{32'd0,          1, 32'sd65536},
    '{32'd4999,       1, 32'sd65536},
    '{32'd5000,       1, 32'sd0},
    '{32'd9999,       1, 32'sd0},
    '{32'd10000,      1, 32'sd65536},
    '{32'hFFFF_FFFF,  1, 32'sd0},
    '{32'd1,          0, 32'sd0},
    '{32'd2500,       0, 32'sd0},
    '{32'd15001,      0, 32'sd0},
    '{32'h8000_0000,  0, 32'sd0},
    '{32'h7FFF_FFFF,  0, 32'sd0},
    '{32'h5555_5555,  0, 32'sd0},
    '{32'hAAAA_AAAA,  0, 32'sd0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("step_square_sine_generator test failed");
    $finish;
  end

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / 64'sd1073741824;
  endfunction

  function automatic longint sine_q30(int unsigned k);
    logic [31:0] u;
    longint t, t2, p, s;
    u = 32'(k) << 22;
    t = longint'(u[29:0]);
    if (u[30]) t = 64'sd1073741824 - t;
    t2 = (t * t) >>> 30;
    p = 64'sd172272;
    p = -64'sd5026995 + q30_mul(p, t2);
    p = 64'sd85569306 + q30_mul(p, t2);
    p = -64'sd693598668 + q30_mul(p, t2);
    p = 64'sd1686629713 + q30_mul(p, t2);
    s = q30_mul(p, t);
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    return u[31] ? -s : s;
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_value(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return VALUE_W'(v);
  endfunction

  function automatic logic signed [VALUE_W-1:0] wave_value_of(logic [TIME_W-1:0] t);
    logic [63:0] phase, k;
    longint s, m, ms, r;
    phase = 64'(t) % 64'(cur_per);
    case (cur_mode)
      MODE_STEP:   return (t >= cur_act) ? sat_value(cur_off + cur_chg) : sat_value(cur_off);
      MODE_SQUARE: return ((phase << 16) < 64'(cur_per) * 64'(cur_duty)) ?
                          sat_value(cur_off + cur_chg) : sat_value(cur_off);
      MODE_SINE: begin
        k = (phase * SINE_N) / 64'(cur_per);
        if (k > SINE_N - 1) k = SINE_N - 1;
        s = sine_q30(int'(k));
        m = (cur_chg < 0) ? -cur_chg : cur_chg;
        ms = (s < 0) ? -s : s;
        r = (m * ms + 64'sd536870912) >>> 30;
        if ((cur_chg < 0) != (s < 0)) r = -r;
        return sat_value(cur_off + r);
      end
      default:     return sat_value(cur_off);
    endcase
  endfunction

  task automatic cfg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = wave_mode_e'(d[1:0]);
      REG_OFFSET: cur_off = longint'(signed'(d));
      REG_CHANGE: cur_chg = longint'(signed'(d));
      REG_PERIOD: cur_per = (d == 0) ? 32'd1 : d;
      REG_DUTY:   cur_duty = (d[16:0] > 17'd65536) ? DUTY_ONE : d[16:0];
      REG_ACT:    cur_act = d;
      default: ;
    endcase
  endtask

  task automatic send_time(logic [TIME_W-1:0] t, bit fixed, logic signed [VALUE_W-1:0] val);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = no_idle ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_ticks_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    wave_q.push_back(fixed ? val : wave_value_of(t));
    accepted++;
  endtask

  task automatic drain_wait();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (wave_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    int r;
    bit held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (!held && accepted >= 400) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) out_stall_i <= 1'b0;
      else if (r < 95) out_stall_i <= 1'b1;
      else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (wave_q.size() == 0) begin
        $error("wave_value: unexpected beat, actual %0d", wave_value_o);
        fail_cnt++;
      end else begin
        if (wave_value_o !== wave_q[0]) begin
          $error("wave_value: expected %0d actual %0d", wave_q[0], wave_value_o);
          fail_cnt++;
        end
        void'(wave_q.pop_front());
      end
    end
  end

  initial begin
    int sel;
    logic [TIME_W-1:0] t;
    cur_mode = MODE_SQUARE;
    cur_off = 0;
    cur_chg = 65536;
    cur_per = 10000;
    cur_duty = 17'd32768;
    cur_act = 1000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_time(dir_tab[i].t, dir_tab[i].fixed, dir_tab[i].val);

    for (int ph = 0; ph < 31; ph++) begin
      drain_wait();
      no_idle = (ph % 5 == 4);
      sel = (ph < 3) ? ph : $urandom_range(3, 9);
      cfg_write(REG_MODE, 32'(ph % 4));
      case (sel)
        1: begin
          cfg_write(REG_OFFSET, 32'h7FFF_FFFF);
          cfg_write(REG_CHANGE, 32'h7FFF_FFFF);
          cfg_write(REG_PERIOD, 32'd0);
          cfg_write(REG_DUTY, 32'h1_FFFF);
          cfg_write(REG_ACT, 32'd0);
        end
        2: begin
          cfg_write(REG_OFFSET, 32'h8000_0000);
          cfg_write(REG_CHANGE, 32'h8000_0000);
          cfg_write(REG_PERIOD, 32'hFFFF_FFFF);
          cfg_write(REG_DUTY, 32'd0);
          cfg_write(REG_ACT, 32'hFFFF_FFFF);
        end
        default: begin
          cfg_write(REG_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom :
                                32'($urandom_range(0, 262144)) - 32'd131072);
          cfg_write(REG_CHANGE, ($urandom_range(0, 3) == 0) ? $urandom :
                                32'($urandom_range(0, 262144)) - 32'd131072);
          case ($urandom_range(0, 6))
            0: cfg_write(REG_PERIOD, 32'd0);
            1: cfg_write(REG_PERIOD, 32'($urandom_range(1, 3)));
            2: cfg_write(REG_PERIOD, 32'($urandom_range(1020, 1030)));
            3: cfg_write(REG_PERIOD, 32'hFFFF_FFFF);
            4: cfg_write(REG_PERIOD, $urandom);
            default: cfg_write(REG_PERIOD, 32'($urandom_range(1, 5000)));
          endcase
          case ($urandom_range(0, 4))
            0: cfg_write(REG_DUTY, 32'd0);
            1: cfg_write(REG_DUTY, 32'd65536);
            2: cfg_write(REG_DUTY, $urandom);
            default: cfg_write(REG_DUTY, 32'($urandom_range(0, 65536)));
          endcase
          cfg_write(REG_ACT, ($urandom_range(0, 1) == 0) ? $urandom :
                             32'($urandom_range(0, 5000)));
          cfg_write(cfg_reg_e'(3'd6 + 3'($urandom_range(0, 1))), $urandom);
        end
      endcase
      for (int n = 0; n < 50; n++) begin
        case ($urandom_range(0, 4))
          0, 1: t = $urandom;
          2: t = 32'($urandom_range(0, 3 * ((cur_per > 100000) ? 100000 : int'(cur_per))));
          3: t = cur_act + 32'($urandom_range(0, 6)) - 32'd3;
          default: t = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
        endcase
        send_time(t, 0, '0);
      end
    end

    drain_wait();
    if (fail_cnt == 0) begin
      $display("step_square_sine_generator test passed");
    end else begin
      $display("step_square_sine_generator test failed");
    end
    $finish;
  end
endmodule
